/* sv/fpss_pkg.sv */
// shared types and constants for the flip-dot panel scan serializer
package fpss_pkg;

  localparam int ROWS        = 26;
  localparam int COLUMNS     = 96;
  localparam int STORE_BYTES = (COLUMNS / 8) * ROWS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PIX_BITS    = 40;
  localparam int OUT_BYTES   = 6;

  localparam logic       OP_WRITE   = 1'b0;
  localparam logic       OP_EMIT    = 1'b1;
  localparam logic [4:0] SLOT_LATCH = 5'd16;
  localparam logic [4:0] SLOT_ODD   = 5'd8;
  localparam logic [4:0] SLOT_TEST  = 5'd24;

  typedef struct packed {
    logic       op;
    logic [8:0] fb_address;
    logic [7:0] fb_data;
    logic       board;
    logic [4:0] segment_slot;
  } fpss_in_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       board_select;
    logic       latch_before;
    logic       last;
  } fpss_out_t;

  typedef struct packed {
    logic              emit;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              board;
    logic [3:0]        segment;
    logic              odd;
    logic              test;
    logic              latch;
  } fpss_cmd_t;

  typedef struct packed {
    logic full;
    logic clearing;
  } fpss_stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PIX,
    BK_TAIL,
    BK_OUT
  } fpss_back_state_t;

endpackage

/* sv/fpss_ram.sv */
// generic single write port ram with registered read
module fpss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 312
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/fpss_front.sv */
// front end: accepts items and classifies them into queue commands
module fpss_front (
  input  logic                  start,
  input  fpss_pkg::fpss_in_t    cmd,
  input  fpss_pkg::fpss_stat_t  stat,
  output logic                  busy,
  output logic                  push,
  output fpss_pkg::fpss_cmd_t   qcmd
);
  import fpss_pkg::*;

  logic accept;
  logic addr_ok;

  assign busy    = stat.clearing | stat.full;
  assign accept  = start & ~busy;
  assign addr_ok = cmd.fb_address < 9'(STORE_BYTES);
  assign push    = accept & ((cmd.op == OP_EMIT) | addr_ok);

  always_comb begin
    qcmd.emit    = (cmd.op == OP_EMIT);
    qcmd.addr    = ADDR_W'(cmd.fb_address);
    qcmd.data    = cmd.fb_data;
    qcmd.board   = cmd.board;
    qcmd.segment = cmd.segment_slot[3:0];
    qcmd.odd     = (cmd.segment_slot >= SLOT_ODD) && (cmd.segment_slot < SLOT_TEST);
    qcmd.test    = (cmd.segment_slot >= SLOT_TEST);
    qcmd.latch   = (cmd.segment_slot == SLOT_LATCH);
  end

endmodule

/* sv/fpss_queue.sv */
// two-entry command queue between front and back
module fpss_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fpss_pkg::fpss_cmd_t push_cmd,
  input  logic                pop,
  output fpss_pkg::fpss_cmd_t head,
  output logic                empty,
  output logic                full
);
  import fpss_pkg::*;

  fpss_cmd_t  slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |=> count != 2'd3)
    else $error("queue count out of range");

endmodule

/* sv/fpss_back.sv */
// back end: frame store, clearing sweep, scan address walk and byte output
module fpss_back (
  input  logic                  clk,
  input  logic                  rst,
  input  fpss_pkg::fpss_cmd_t   head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  clearing,
  output logic                  strobe,
  output fpss_pkg::fpss_out_t   result
);
  import fpss_pkg::*;

  fpss_back_state_t state, state_next;

  logic [ADDR_W-1:0] clr_addr;
  logic              board;
  logic              odd;
  logic              trl;
  logic              latch;
  logic [4:0]        row_base;
  logic [5:0]        row;
  logic [6:0]        col;
  logic [5:0]        j;
  logic [3:0]        jm;
  logic              jz;
  logic [5:0]        n;
  logic [2:0]        k;
  logic [PIX_BITS-1:0] shreg;
  logic              pend;
  logic              pend_ok;
  logic [2:0]        pend_bit;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              use_next_col;
  logic signed [8:0] xs, ys, xm, ym;
  logic              in_range;
  logic [4:0]        load_rs;

  fpss_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pixel coordinate of the current scan step
  always_comb begin
    use_next_col = 1'b0;
    ys           = $signed({3'b000, row});
    if (odd) begin
      if (jz) begin
        use_next_col = 1'b1;
        ys           = board ? 9'sd12 : 9'sd25;
      end
    end else begin
      if (jz) begin
        use_next_col = 1'b1;
        ys           = board ? 9'sd11 : 9'sd24;
      end else if ((jm != 4'd0) && (row == 6'd1) && board) begin
        use_next_col = 1'b1;
        ys           = 9'sd0;
      end else if ((jm != 4'd0) && (row == 6'd14) && !board) begin
        use_next_col = 1'b1;
        ys           = 9'sd13;
      end else if (row == 6'd14) begin
        ys = $signed({3'b000, row}) - 9'sd1;
      end else begin
        ys = $signed({3'b000, row}) - 9'sd2;
      end
    end
    xs = $signed({2'b00, col}) + (use_next_col ? 9'sd1 : 9'sd0);
    if (ys < 9'sd13) begin
      xm = 9'(COLUMNS - 1) - xs;
      ym = 9'sd12 - ys;
    end else begin
      xm = xs;
      ym = ys;
    end
    in_range  = !xm[8] && (xm < 9'(COLUMNS)) && !ym[8] && (ym < 9'(ROWS));
    ram_raddr = in_range ? (ADDR_W'(xm[6:3]) * ADDR_W'(ROWS) + ADDR_W'(ym[4:0]))
                         : '0;
  end

  assign load_rs = head.odd ? (head.board ? 5'd0 : 5'd13) : (head.board ? 5'd1 : 5'd14);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (clr_addr == ADDR_W'(STORE_BYTES - 1)) state_next = BK_IDLE;
      BK_IDLE:  if (!empty && head.emit) state_next = BK_PIX;
      BK_PIX:   if (n == 6'(PIX_BITS - 1)) state_next = BK_TAIL;
      BK_TAIL:  state_next = BK_OUT;
      BK_OUT:   if (k == 3'(OUT_BYTES - 1)) state_next = BK_IDLE;
      default:  state_next = BK_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    strobe    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = head.addr;
    ram_wdata = head.data;
    ram_re    = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      BK_IDLE: begin
        pop    = !empty;
        ram_we = !empty && !head.emit;
      end
      BK_PIX:  ram_re = 1'b1;
      BK_TAIL: ;
      BK_OUT:  strobe = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    result.spi_byte     = (k == 3'(OUT_BYTES - 1)) ? {7'd0, trl} : shreg[7:0];
    result.board_select = ~board;
    result.latch_before = latch && (k == 3'd0);
    result.last         = (k == 3'(OUT_BYTES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      pend <= (state == BK_PIX);
    end

    pend_ok  <= in_range;
    pend_bit <= xm[2:0];
    if (pend) begin
      shreg <= {pend_ok & ram_rdata[pend_bit], shreg[PIX_BITS-1:1]};
    end

    unique case (state)
      BK_IDLE: begin
        board     <= head.board;
        odd       <= head.odd;
        trl       <= head.odd & ~head.test;
        latch     <= head.latch;
        row_base  <= load_rs;
        row       <= 6'(load_rs) + 6'd2;
        col       <= 7'(COLUMNS - 1) - 7'(head.segment) * 7'd6;
        j         <= {5'd0, ~head.segment[0]};
        jm        <= {3'd0, ~head.segment[0]};
        jz        <= head.segment[0];
        n         <= '0;
        k         <= '0;
      end
      BK_PIX: begin
        if (j == 6'd6 || j == 6'd13 || j == 6'd19 || j == 6'd26 || j == 6'd32) begin
          col <= col - 7'd1;
        end
        if (jm == 4'd6) begin
          row <= 6'(row_base);
        end else if (jm == 4'd0) begin
          row <= 6'(row_base) + 6'd2;
        end else begin
          row <= row + 6'd2;
        end
        jm <= (jm == 4'd12) ? 4'd0 : jm + 4'd1;
        j  <= j + 6'd1;
        jz <= 1'b0;
        n  <= n + 6'd1;
      end
      BK_OUT: begin
        k     <= k + 3'd1;
        shreg <= {8'd0, shreg[PIX_BITS-1:8]};
      end
      default: ;
    endcase
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
      strobe && result.last |=> !strobe)
    else $error("transfer after last byte");

  a_bytes_run: assert property (@(posedge clk) disable iff (rst)
      strobe && !result.last |=> strobe)
    else $error("gap inside segment bytes");

  a_latch_first: assert property (@(posedge clk) disable iff (rst)
      strobe && result.latch_before |=> strobe && !result.latch_before)
    else $error("latch flag beyond first byte");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
      (state == BK_PIX || state == BK_OUT) |-> !ram_we && !pop)
    else $error("store write or pop during emit");

endmodule

/* sv/flipdot_panel_scan_serializer.sv */
// flip-dot panel scan serializer top level
//
// one command channel: an item transfers on a rising edge with start high and
// busy low. op write stores one frame byte (addresses past the store are
// dropped); op emit produces six result bytes for one board and segment slot.
// results appear on result with strobe high for exactly one cycle each, six
// in consecutive cycles, last set on the sixth; the receiver cannot stall.
// commands pass through a two-entry queue, so busy rises when it is full and
// while the frame store is cleared. a write stores its byte in the back end. an
// emit loads, walks the scan order with one frame store read per pixel (the
// single read port sets this), collects the last read, then sends six bytes.
// after reset the frame store is cleared by a sweep of all 312 bytes, one byte
// a cycle, with busy held high; then the block takes commands.
module flipdot_panel_scan_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fpss_pkg::fpss_in_t  cmd,
  output logic                busy,
  output logic                strobe,
  output fpss_pkg::fpss_out_t result
);
  import fpss_pkg::*;

  fpss_stat_t stat;
  fpss_cmd_t  qcmd;
  fpss_cmd_t  head;
  logic       push;
  logic       pop;
  logic       empty;
  logic       full;
  logic       clearing;

  assign stat.full     = full;
  assign stat.clearing = clearing;

  fpss_front u_front (
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .push  (push),
    .qcmd  (qcmd)
  );

  fpss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (qcmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  fpss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .clearing (clearing),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

/* sim/tb_flipdot_panel_scan_serializer.sv */
// self-checking testbench for the flip-dot panel scan serializer
module tb_flipdot_panel_scan_serializer;
  import fpss_pkg::*;

  localparam int RANDOM_ITEMS = 436;
  localparam int WATCHDOG     = 3000;
  localparam int TAIL_CYCLES  = 100;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    fpss_in_t        item;
    logic            typed;
    logic [5:0][7:0] bytes;
  } stim_row_t;

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, SLOT_LATCH}, 1'b1, 48'h01_0000000000},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b0, 5'd0},       1'b1, 48'h00_0000000000},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, 5'd31},      1'b1, 48'h00_0000000000},
    '{'{OP_EMIT,  9'd511, 8'hff, 1'b0, 5'd23},      1'b1, 48'h01_0000000000},
    '{'{OP_WRITE, 9'd511, 8'hff, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd312, 8'hff, 1'b1, 5'd31},      1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, SLOT_ODD},   1'b1, 48'h01_0000000000},
    '{'{OP_WRITE, 9'd0,   8'hff, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd311, 8'hff, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd25,  8'hff, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd286, 8'hff, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd12,  8'haa, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd13,  8'h55, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd298, 8'h81, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_WRITE, 9'd299, 8'h7e, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, 5'd0},       1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b0, 5'd0},       1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, SLOT_ODD},   1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b0, 5'd15},      1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, SLOT_LATCH}, 1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b0, 5'd23},      1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, SLOT_TEST},  1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b0, 5'd31},      1'b0, 48'h0},
    '{'{OP_EMIT,  9'd0,   8'h00, 1'b1, 5'd7},       1'b0, 48'h0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  fpss_in_t  cmd;
  logic      busy;
  logic      strobe;
  fpss_out_t result;

  logic [7:0] panel_store [STORE_BYTES];
  fpss_out_t  pending_bytes [$];
  int         failures;
  int         bytes_checked;
  int         writes_sent;
  int         emits_sent;
  int         quiet_cycles;
  logic       calm;

  flipdot_panel_scan_serializer u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic pixel(int x, int y);
    if (y < 13) begin
      x = COLUMNS - 1 - x;
      y = 12 - y;
    end
    if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS) return 1'b0;
    return panel_store[(x / 8) * ROWS + y][x % 8];
  endfunction

  // pixel scan order of one segment slot plus its trailer, lsb first
  function automatic logic [5:0][7:0] segment_bytes(logic board, logic [4:0] slot);
    logic [47:0] bits;
    logic        odd;
    logic        test;
    logic        b;
    int          row_base;
    int          row;
    int          col;
    int          first;
    int          n;
    int          j;
    bits      = '0;
    n         = 0;
    odd       = (slot >= SLOT_ODD) && (slot < SLOT_TEST);
    test      = (slot >= SLOT_TEST);
    row_base  = odd ? (board ? 0 : 13) : (board ? 1 : 14);
    row       = row_base + 2;
    col       = COLUMNS - 1 - int'(slot[3:0]) * 6;
    first     = slot[0] ? 0 : 1;
    for (j = first; j < PIX_BITS + first; j++) begin
      if (odd) begin
        b = (j != 0) ? pixel(col, row) : pixel(col + 1, board ? 12 : 25);
      end else if (j == 0) begin
        b = pixel(col + 1, board ? 11 : 24);
      end else if ((j % 13) != 0 && row == 1 && board) begin
        b = pixel(col + 1, 0);
      end else if ((j % 13) != 0 && row == 14 && !board) begin
        b = pixel(col + 1, 13);
      end else begin
        b = pixel(col, (row - 2 == 12) ? row - 1 : row - 2);
      end
      bits[n] = b;
      n++;
      if (j == 6 || j == 13 || j == 19 || j == 26 || j == 32) col--;
      if (j >= 6 && (j - 6) % 13 == 0) row = row_base;
      else if (j % 13 == 0) row = row_base + 2;
      else row += 2;
    end
    bits[PIX_BITS] = !test && odd;
    return bits;
  endfunction

  function automatic void predict(fpss_in_t it, logic typed, logic [5:0][7:0] typed_bytes);
    logic [5:0][7:0] bytes;
    fpss_out_t       r;
    if (it.op == OP_WRITE) begin
      if (it.fb_address < STORE_BYTES) panel_store[it.fb_address] = it.fb_data;
    end else begin
      bytes = typed ? typed_bytes : segment_bytes(it.board, it.segment_slot);
      for (int k = 0; k < OUT_BYTES; k++) begin
        r.spi_byte     = bytes[k];
        r.board_select = ~it.board;
        r.latch_before = (k == 0) && (it.segment_slot == SLOT_LATCH);
        r.last         = (k == OUT_BYTES - 1);
        pending_bytes.push_back(r);
      end
    end
  endfunction

  function automatic int idle_cycles();
    int roll;
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(0, 7))
      0: return 8'hff;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input fpss_in_t it, input logic typed,
                           input logic [5:0][7:0] typed_bytes);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= it;
    do @(posedge clk); while (busy);
    predict(it, typed, typed_bytes);
    if (it.op == OP_EMIT) emits_sent++;
    else writes_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    fpss_out_t want;
    if (!rst && strobe) begin
      if (pending_bytes.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: byte %02h sel %0b latch %0b last %0b",
                   result.spi_byte, result.board_select, result.latch_before, result.last);
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (result.spi_byte !== want.spi_byte || result.board_select !== want.board_select ||
            result.latch_before !== want.latch_before || result.last !== want.last) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("mismatch: byte %02h/%02h sel %0b/%0b latch %0b/%0b last %0b/%0b",
                     want.spi_byte, result.spi_byte, want.board_select, result.board_select,
                     want.latch_before, result.latch_before, want.last, result.last);
        end
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if ((!rst && start && !busy) || (!rst && strobe)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fpss_in_t it;
    int       random_sent;
    int       nw;
    int       ne;
    int       base;
    logic     drained;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    failures      = 0;
    bytes_checked = 0;
    writes_sent   = 0;
    emits_sent    = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    random_sent   = 0;
    drained       = 1'b0;
    foreach (panel_store[a]) panel_store[a] = 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].bytes);

    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        // fill part of the frame, then scan it out
        nw   = $urandom_range(2, 10);
        base = $urandom_range(0, STORE_BYTES - 1);
        for (int w = 0; w < nw; w++) begin
          it.op           = OP_WRITE;
          it.fb_address   = $urandom_range(0, 1) ? 9'((base + w) % STORE_BYTES)
                                                 : 9'($urandom_range(0, STORE_BYTES - 1));
          it.fb_data      = pixel_byte();
          it.board        = 1'($urandom);
          it.segment_slot = 5'($urandom);
          send_item(it, 1'b0, '0);
          random_sent++;
        end
        ne = $urandom_range(1, 4);
        for (int e = 0; e < ne; e++) begin
          it.op           = OP_EMIT;
          it.fb_address   = 9'($urandom);
          it.fb_data      = 8'($urandom);
          it.board        = 1'($urandom);
          it.segment_slot = 5'($urandom_range(0, 31));
          send_item(it, 1'b0, '0);
          random_sent++;
        end
      end else begin
        it            = fpss_in_t'($urandom);
        it.fb_address = 9'($urandom_range(0, 511));
        send_item(it, 1'b0, '0);
        random_sent++;
      end
      if (!drained && random_sent >= RANDOM_ITEMS / 2) begin
        // hold off until every byte in flight is back
        drained = 1'b1;
        start <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
      end
    end

    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      failures += pending_bytes.size();
      $display("%0d expected bytes never arrived", pending_bytes.size());
    end

    $display("covered %0d frame writes and %0d segment emits on both boards, all 32 slots",
             writes_sent, emits_sent);
    $display("%0d serial bytes checked, %0d failures", bytes_checked, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
sv/fpss_pkg.sv
sv/fpss_ram.sv
sv/fpss_front.sv
sv/fpss_queue.sv
sv/fpss_back.sv
sv/flipdot_panel_scan_serializer.sv
sim/tb_flipdot_panel_scan_serializer.sv
